[design/masked_byte_pattern_search_unit_assert.svh]
// Assertion macros shared by the masked byte pattern search unit.
// Used by mbps_fifo and mbps_back; relies on clk and rst_n in the including module.
`ifndef MASKED_BYTE_PATTERN_SEARCH_UNIT_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SEARCH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define MBPS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// antecedent holds -> consequent holds in the next cycle
`define MBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
// condition must never be seen
`define MBPS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MBPS_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define MBPS_ASSERT_NEXT(lbl, ante, cons, msg)
`define MBPS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[design/mbps_pkg.sv]
// Shared types and constants of the masked byte pattern search unit.
// No dependencies; imported by mbps_front, mbps_back and the top level.
package mbps_pkg;

  // default sizes
  localparam int MAX_PATTERN_DEF = 64;
  localparam int OFFSET_BITS_DEF = 32;
  localparam int IN_DEPTH_DEF    = 2;
  localparam int RES_DEPTH_DEF   = 4;

  // fixed field widths
  localparam int IDX_W  = 6;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int MOFS_W = 32;

  // item opcode
  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_SCAN = 1'b1
  } op_t;

  // classified item held in the front queue
  typedef struct packed {
    op_t               kind;
    logic              idx_ok;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] data;
    logic              last;
  } item_t;

  // head of the front queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } fe_req_t;

  // one search result
  typedef struct packed {
    logic              found;
    logic [MOFS_W-1:0] offset;
  } res_t;

  localparam int ITEM_W = $bits(item_t);
  localparam int RES_W  = $bits(res_t);

endpackage

[design/mbps_fifo.sv]
// Small first-word-fall-through queue used for items and results.
// Depends on masked_byte_pattern_search_unit_assert.svh for its checks.
`include "masked_byte_pattern_search_unit_assert.svh"
module mbps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0]    cnt_r, cnt_nxt;

  // status
  assign full    = (cnt_r == LW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign level   = cnt_r;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + LW'(push) - LW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `MBPS_ASSERT_NEVER(a_no_overflow, push && full, "queue written while full")
  `MBPS_ASSERT_NEVER(a_no_underflow, pop && empty, "queue read while empty")
  `MBPS_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "fill count lost an item")

endmodule

[design/mbps_front.sv]
// Front end: takes items from the input channel, decodes them and queues them.
// Depends on mbps_pkg and mbps_fifo.
module mbps_front import mbps_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int DEPTH       = IN_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_op,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [BYTE_W-1:0] in_entry_value,
  input  logic [BYTE_W-1:0] in_entry_mask,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_last,
  output fe_req_t           fe,
  input  logic              fe_pop
);

  item_t                       item;
  logic [ITEM_W-1:0]           q_rd;
  logic                        q_empty;
  logic [$clog2(DEPTH+1)-1:0]  q_level;

  // classify: loads check the index against the store, scans keep the byte
  always_comb begin
    item        = '0;
    item.kind   = op_t'(in_op);
    item.idx    = in_entry_index;
    item.value  = in_entry_value;
    item.mask   = in_entry_mask;
    item.data   = in_data_byte;
    item.last   = in_last;
    case (op_t'(in_op))
      OP_LOAD: item.idx_ok = (int'(in_entry_index) < MAX_PATTERN);
      OP_SCAN: item.idx_ok = 1'b0;
      default: item.idx_ok = 1'b0;
    endcase
  end

  mbps_fifo #(
    .WIDTH(ITEM_W),
    .DEPTH(DEPTH)
  ) u_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_push && !in_full),
    .wr_data(item),
    .pop    (fe_pop),
    .rd_data(q_rd),
    .full   (in_full),
    .empty  (q_empty),
    .level  (q_level)
  );

  // head of queue; level kept visible for the empty flag only
  always_comb begin
    fe.item  = item_t'(q_rd);
    fe.valid = !q_empty && (q_level != '0);
  end

endmodule

[design/mbps_back.sv]
// Back end: pattern store, byte window, masked compare and result decision.
// Depends on mbps_pkg and masked_byte_pattern_search_unit_assert.svh.
`include "masked_byte_pattern_search_unit_assert.svh"
module mbps_back import mbps_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int RES_DEPTH   = RES_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [LEN_W-1:0]               cfg_len,
  input  fe_req_t                        fe,
  output logic                           fe_pop,
  input  logic [$clog2(RES_DEPTH+1)-1:0] res_level,
  output logic                           res_push,
  output res_t                           res
);

  localparam int IDXW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LENW = $clog2(MAX_PATTERN + 1);
  localparam int CW   = (OFFSET_BITS > LENW) ? OFFSET_BITS : LENW;
  localparam int RLW  = $clog2(RES_DEPTH + 1);

  logic [LENW-1:0]        alen;
  logic [LENW-1:0]        shamt;
  logic [BYTE_W-1:0]      val_r  [MAX_PATTERN];
  logic [BYTE_W-1:0]      msk_r  [MAX_PATTERN];
  logic [BYTE_W-1:0]      aval_r [MAX_PATTERN];
  logic [BYTE_W-1:0]      amsk_r [MAX_PATTERN];
  logic [BYTE_W-1:0]      rv     [MAX_PATTERN];
  logic [BYTE_W-1:0]      rm     [MAX_PATTERN];
  logic [BYTE_W-1:0]      win_r  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] ok_r, ok_nxt;
  logic [OFFSET_BITS-1:0] cnt_r, cnt_nxt;
  logic                   fresh_r, fresh_nxt;
  logic                   st1_v_r, st1_v_nxt;
  logic                   st1_last_r;
  logic                   st2_v_r, st2_v_nxt;
  logic                   st2_last_r;
  logic                   st2_enough_r;
  logic [MOFS_W-1:0]      st2_ofs_r;
  logic [CW-1:0]          diff;
  logic                   mrep_r, mrep_nxt;
  logic                   room;
  logic                   take_load, take_scan;
  logic                   match;

  // active length, clipped to the store
  always_comb begin
    if (int'(cfg_len) > MAX_PATTERN) begin
      alen = LENW'(MAX_PATTERN);
    end else begin
      alen = LENW'(cfg_len);
    end
    shamt = LENW'(MAX_PATTERN) - alen;
  end

  // issue: scans only when every in-flight scan has a result slot
  always_comb begin
    room      = (int'(res_level) + int'(st1_v_r) + int'(st2_v_r)) < RES_DEPTH;
    take_load = 1'b0;
    take_scan = 1'b0;
    case (fe.item.kind)
      OP_LOAD: take_load = fe.valid;
      OP_SCAN: take_scan = fe.valid && room;
      default: ;
    endcase
    fe_pop = take_load || take_scan;
  end

  // pattern store, one entry per load
  always_ff @(posedge clk) begin
    if (take_load && fe.item.idx_ok) begin
      val_r[IDXW'(fe.item.idx)] <= fe.item.value;
      msk_r[IDXW'(fe.item.idx)] <= fe.item.mask;
    end
  end

  // align pattern to the window: entry i faces slot alen-1-i.
  // reverse the store, then a log shifter moves it down by MAX_PATTERN-alen
  always_comb begin
    int src;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      rv[k] = val_r[MAX_PATTERN-1-k];
      rm[k] = msk_r[MAX_PATTERN-1-k];
    end
    for (int b = 0; b < LENW; b++) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        src = ((k + (1 << b)) < MAX_PATTERN) ? (k + (1 << b)) : k;
        if (shamt[b]) begin
          if ((k + (1 << b)) < MAX_PATTERN) begin
            rv[k] = rv[src];
            rm[k] = rm[src];
          end else begin
            rv[k] = '0;
            rm[k] = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      aval_r[k] <= rv[k];
      amsk_r[k] <= rm[k];
    end
  end

  // stage 1: shift the window and count region bytes
  always_comb begin
    cnt_nxt   = cnt_r;
    fresh_nxt = fresh_r;
    if (take_scan) begin
      if (fresh_r) begin
        cnt_nxt = OFFSET_BITS'(1);
      end else if (cnt_r != '1) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      fresh_nxt = fe.item.last;
    end
    st1_v_nxt = take_scan;
  end

  always_ff @(posedge clk) begin
    if (take_scan) begin
      win_r[0] <= fe.item.data;
      for (int k = 1; k < MAX_PATTERN; k++) begin
        win_r[k] <= win_r[k-1];
      end
      st1_last_r <= fe.item.last;
    end
  end

  // stage 2: per-slot masked compare, length check and offset
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      ok_nxt[j] = (j >= int'(alen)) ||
                  (((win_r[j] ^ aval_r[j]) & amsk_r[j]) == '0);
    end
    diff      = CW'(cnt_r) - CW'(alen);
    st2_v_nxt = st1_v_r;
  end

  always_ff @(posedge clk) begin
    if (st1_v_r) begin
      ok_r         <= ok_nxt;
      st2_last_r   <= st1_last_r;
      st2_enough_r <= (CW'(cnt_r) >= CW'(alen));
      st2_ofs_r    <= MOFS_W'(diff);
    end
  end

  // stage 3: decide the result; one per region at most
  always_comb begin
    match      = st2_v_r && st2_enough_r && (alen != '0) && (&ok_r);
    res_push   = st2_v_r && !mrep_r && (match || st2_last_r);
    res.found  = match;
    res.offset = match ? st2_ofs_r : '0;
    mrep_nxt   = mrep_r;
    if (st2_v_r) begin
      if (st2_last_r) begin
        mrep_nxt = 1'b0;
      end else if (match) begin
        mrep_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      fresh_r <= 1'b1;
      st1_v_r <= 1'b0;
      st2_v_r <= 1'b0;
      mrep_r  <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      fresh_r <= fresh_nxt;
      st1_v_r <= st1_v_nxt;
      st2_v_r <= st2_v_nxt;
      mrep_r  <= mrep_nxt;
    end
  end

  `MBPS_ASSERT_NEVER(a_res_room, res_push && (res_level >= RLW'(RES_DEPTH)), "result queue overrun")
  `MBPS_ASSERT_IMPLIES(a_miss_at_end, res_push && !res.found, st2_last_r, "not-found before region end")
  `MBPS_ASSERT_NEXT(a_found_holds, res_push && res.found && !st2_last_r, mrep_r, "match not recorded")

endmodule

[design/masked_byte_pattern_search_unit.sv]
// Top level of the masked byte pattern search unit.
// Depends on mbps_pkg, mbps_front, mbps_back and mbps_fifo.
//
// Usage:
//  - Configuration: cfg_valid/cfg_ready write pattern_length (1..MAX_PATTERN,
//    larger counts as MAX_PATTERN, 0 never matches). cfg_ready is always high.
//    Write it only while no item is in flight.
//  - Input queue: item taken when in_push is high and in_full low. in_op = 0
//    loads entry in_entry_index (value and mask, mask bit 0 = wildcard);
//    in_op = 1 streams in_data_byte, in_last closes the region.
//  - Result queue: out_found/out_match_offset valid while out_empty is low,
//    taken when out_pop is high. One result per region: found with the start
//    offset, or not-found at the last byte.
//  - Throughput: one item per cycle unless a scan waits for result room;
//    all slots compare in parallel over a shifted byte window, in three stages.
//  - Path: a byte causing a result passes the input queue, the window stage
//    and the compare stage, then the result queue that drives the result ports.
//  - Stalls: a stalled result queue (four deep) holds back region bytes in the
//    two-deep input queue, so in_full rises; loads at the queue head still drain.
//  - Reset: synchronous, rst_n low; queues empty, pattern_length = 1, a new
//    region starts. Pattern entries keep no reset value and must be loaded.
module masked_byte_pattern_search_unit import mbps_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_pattern_length,
  // input items
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_op,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [BYTE_W-1:0] in_entry_value,
  input  logic [BYTE_W-1:0] in_entry_mask,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_last,
  // results
  output logic              out_empty,
  input  logic              out_pop,
  output logic              out_found,
  output logic [MOFS_W-1:0] out_match_offset
);

  localparam int RLW = $clog2(RES_DEPTH_DEF + 1);

  logic [LEN_W-1:0] len_r, len_nxt;
  fe_req_t          fe;
  logic             fe_pop;
  logic             res_push;
  res_t             res_wr;
  res_t             res_rd;
  logic [RES_W-1:0] res_rd_bits;
  logic [RLW-1:0]   res_level;
  logic             res_full;

  // configuration register
  assign cfg_ready = 1'b1;
  always_comb begin
    len_nxt = len_r;
    if (cfg_valid && cfg_ready) begin
      len_nxt = cfg_pattern_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(1);
    end else begin
      len_r <= len_nxt;
    end
  end

  mbps_front #(
    .MAX_PATTERN(MAX_PATTERN),
    .DEPTH      (IN_DEPTH_DEF)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_entry_index(in_entry_index),
    .in_entry_value(in_entry_value),
    .in_entry_mask (in_entry_mask),
    .in_data_byte  (in_data_byte),
    .in_last       (in_last),
    .fe            (fe),
    .fe_pop        (fe_pop)
  );

  mbps_back #(
    .MAX_PATTERN(MAX_PATTERN),
    .OFFSET_BITS(OFFSET_BITS),
    .RES_DEPTH  (RES_DEPTH_DEF)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_len  (len_r),
    .fe       (fe),
    .fe_pop   (fe_pop),
    .res_level(res_level),
    .res_push (res_push),
    .res      (res_wr)
  );

  // result queue
  mbps_fifo #(
    .WIDTH(RES_W),
    .DEPTH(RES_DEPTH_DEF)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res_push),
    .wr_data(res_wr),
    .pop    (out_pop && !out_empty),
    .rd_data(res_rd_bits),
    .full   (res_full),
    .empty  (out_empty),
    .level  (res_level)
  );

  // result ports; an empty queue shows a cleared item
  always_comb begin
    res_rd = res_t'(res_rd_bits);
    if (out_empty) begin
      res_rd = '0;
    end
    out_found        = res_rd.found;
    out_match_offset = res_rd.offset;
  end

endmodule
